// ----- rtl/palette_table_masked_write_assert.svh -----
// Assertion macros shared by the palette table modules.
`ifndef PALETTE_TABLE_MASKED_WRITE_ASSERT_SVH
`define PALETTE_TABLE_MASKED_WRITE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define PMW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PMW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Expression must hold at every clock edge out of reset.
`define PMW_ASSERT_ALW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`else

`define PMW_ASSERT_IMP(lbl, ante, cons, msg)
`define PMW_ASSERT_NXT(lbl, ante, cons, msg)
`define PMW_ASSERT_ALW(lbl, expr, msg)

`endif

`endif

// ----- rtl/pmw_pkg.sv -----
// Shared types and constants of the palette table.
package pmw_pkg;

  localparam int unsigned OPC_W    = 2;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned CH_W     = 8;
  localparam int unsigned RGB_W    = 3 * CH_W;
  localparam int unsigned COLORS_W = 9;
  localparam int unsigned OPAQUE_W = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = COLORS_W;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [OPC_W-1:0] OP_READ  = 2'd0;
  localparam logic [OPC_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OPC_W-1:0] OP_BULK  = 2'd2;
  localparam logic [OPC_W-1:0] OP_NONE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_COLORS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPAQUE = 1'b1;

  localparam logic [COLORS_W-1:0] COLORS_RST = 9'd256;
  localparam logic [OPAQUE_W-1:0] OPAQUE_RST = 8'd64;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_SWEEP = 4'b1000
  } pmw_state_t;

  typedef struct packed {
    logic clear_wr;
    logic single_wr;
    logic sweep_start;
    logic sweep_step;
    logic res_load;
    logic res_ok;
    logic res_from_mem;
  } pmw_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic in_range;
    logic lim_zero;
    logic sweep_last;
  } pmw_sts_t;

endpackage

// ----- rtl/pmw_datapath.sv -----
// Palette memory, configuration registers, sweep counter and result register.
`include "palette_table_masked_write_assert.svh"

module pmw_datapath #(
  parameter int unsigned NUM_ENTRIES = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [pmw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pmw_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [pmw_pkg::IDX_W-1:0]           in_index,
  input  logic [pmw_pkg::CH_W-1:0]            in_red,
  input  logic [pmw_pkg::CH_W-1:0]            in_green,
  input  logic [pmw_pkg::CH_W-1:0]            in_blue,
  input  pmw_pkg::pmw_cmd_t                   cmd,
  output pmw_pkg::pmw_sts_t                   sts,
  output logic                                out_ok,
  output logic [pmw_pkg::CH_W-1:0]            out_red,
  output logic [pmw_pkg::CH_W-1:0]            out_green,
  output logic [pmw_pkg::CH_W-1:0]            out_blue
);
  import pmw_pkg::*;

  localparam int unsigned AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(NUM_ENTRIES + 1);
  localparam int unsigned LW = (CW > COLORS_W) ? CW : COLORS_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(NUM_ENTRIES);
  localparam logic [CW-1:0] LAST_CNT = CW'(NUM_ENTRIES - 1);

  logic [RGB_W-1:0]    mem [NUM_ENTRIES];
  logic [RGB_W-1:0]    rd_data_r;

  logic [COLORS_W-1:0] colors_r;
  logic [OPAQUE_W-1:0] opaque_r;

  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    pattern_r;
  logic [IDX_W-1:0]    mask_r;
  logic [RGB_W-1:0]    rgb_r;

  logic                ok_r;
  logic [RGB_W-1:0]    res_r;

  logic [LW-1:0]       colors_l, lim, idx_l, cnt_l;
  logic [AW-1:0]       idx_addr, cnt_addr, wr_addr;
  logic [RGB_W-1:0]    wr_data;
  logic                wr_en;
  logic                match;
  logic [COLORS_W-1:0] ob2m1;
  logic [OPAQUE_W-1:0] obm1;
  logic                hit_low, hit_ob;
  logic [IDX_W-1:0]    mask_nxt;

  // Active limit is the smaller of the color count and the store depth.
  assign colors_l = LW'(colors_r);
  assign lim      = (colors_l > DEPTH_L) ? DEPTH_L : colors_l;
  assign idx_l    = LW'(in_index);
  assign cnt_l    = LW'(cnt_r);
  assign idx_addr = idx_l[AW-1:0];
  assign cnt_addr = cnt_l[AW-1:0];

  assign sts.in_range   = idx_l < lim;
  assign sts.lim_zero   = lim == '0;
  assign sts.sweep_last = (cnt_l + LW'(1)) == lim;
  assign sts.clear_last = cnt_r == LAST_CNT;

  // Layer mask: add the opaque bit if any pattern bit at or below it is set,
  // add all bits below it if the opaque bit itself is set.
  assign ob2m1    = {opaque_r, 1'b0} - COLORS_W'(1);
  assign obm1     = opaque_r - OPAQUE_W'(1);
  assign hit_low  = |(COLORS_W'(in_index) & ob2m1);
  assign hit_ob   = |(in_index & opaque_r);
  assign mask_nxt = in_index | (hit_low ? opaque_r : '0) | (hit_ob ? obm1 : '0);

  assign match = (cnt_l[IDX_W-1:0] & mask_r) == pattern_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_addr;
    wr_data = rgb_r;
    if (cmd.clear_wr) begin
      wr_en   = 1'b1;
      wr_data = '0;
    end else if (cmd.sweep_step) begin
      wr_en = match;
    end else if (cmd.single_wr) begin
      wr_en   = 1'b1;
      wr_addr = idx_addr;
      wr_data = {in_red, in_green, in_blue};
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clear_wr) begin
      cnt_nxt = sts.clear_last ? '0 : cnt_r + CW'(1);
    end else if (cmd.sweep_start) begin
      cnt_nxt = '0;
    end else if (cmd.sweep_step) begin
      cnt_nxt = sts.sweep_last ? '0 : cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[idx_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colors_r <= COLORS_RST;
      opaque_r <= OPAQUE_RST;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_COLORS: colors_r <= cfg_data;
          CFG_OPAQUE: opaque_r <= cfg_data[OPAQUE_W-1:0];
          default:    ;
        endcase
      end
    end
  end

  // Latch the bulk transaction for the sweep, and load the result register.
  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      pattern_r <= in_index;
      mask_r    <= mask_nxt;
      rgb_r     <= {in_red, in_green, in_blue};
    end
    if (cmd.res_load) begin
      ok_r  <= cmd.res_ok;
      res_r <= cmd.res_from_mem ? rd_data_r : '0;
    end
  end

  assign out_ok    = ok_r;
  assign out_red   = res_r[3*CH_W-1:2*CH_W];
  assign out_green = res_r[2*CH_W-1:CH_W];
  assign out_blue  = res_r[CH_W-1:0];

  `PMW_ASSERT_IMP(a_sweep_in_limit, cmd.sweep_step, cnt_l < lim, "sweep beyond active limit")
  `PMW_ASSERT_IMP(a_clear_in_depth, cmd.clear_wr, cnt_l < DEPTH_L, "clear beyond store depth")

endmodule

// ----- rtl/pmw_ctrl.sv -----
// Controller state machine: handshakes, clearing pass, read and sweep sequencing.
`include "palette_table_masked_write_assert.svh"

module pmw_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [pmw_pkg::OPC_W-1:0] in_opcode,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  pmw_pkg::pmw_sts_t         sts,
  output pmw_pkg::pmw_cmd_t         cmd
);
  import pmw_pkg::*;

  pmw_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;
  logic       take;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take) begin
          case (in_opcode)
            OP_READ: begin
              if (sts.in_range) begin
                state_nxt = ST_READ;
              end else begin
                cmd.res_load = 1'b1;
              end
            end
            OP_WRITE: begin
              cmd.single_wr = sts.in_range;
              cmd.res_load  = 1'b1;
              cmd.res_ok    = sts.in_range;
            end
            OP_BULK: begin
              cmd.sweep_start = 1'b1;
              if (sts.lim_zero) begin
                cmd.res_load = 1'b1;
                cmd.res_ok   = 1'b1;
              end else begin
                state_nxt = ST_SWEEP;
              end
            end
            default: begin
              cmd.res_load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.res_load     = 1'b1;
        cmd.res_ok       = 1'b1;
        cmd.res_from_mem = 1'b1;
        state_nxt        = ST_IDLE;
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          cmd.res_load = 1'b1;
          cmd.res_ok   = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Hold the result until the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `PMW_ASSERT_IMP(a_sweep_slot_empty, state_r == ST_SWEEP, !out_valid_r, "result pending in sweep")
  `PMW_ASSERT_NXT(a_read_goes_wait, take && in_opcode == OP_READ && sts.in_range, state_r == ST_READ, "read did not wait for memory")
  `PMW_ASSERT_NXT(a_read_delivers, state_r == ST_READ, out_valid_r, "read result not loaded")
  `PMW_ASSERT_ALW(a_one_writer, $onehot0({cmd.clear_wr, cmd.single_wr, cmd.sweep_step}), "memory write port conflict")

endmodule

// ----- rtl/palette_table_masked_write.sv -----
// Top level of the palette table with masked bulk write.
//
// Input channel in_*: one transaction per request (read, single write, or masked
// bulk write). Result channel out_*: exactly one transaction per request, in order.
// Configuration channel cfg_*: always ready; write only while the block is idle.
//
// Sequencing: a single write has its result registered at the accept edge; a read
// passes the registered memory read port and then the result register. A bulk
// write walks L = min(colors_in_use, NUM_ENTRIES) entries of the store, one entry
// a cycle through the single write port. A rejected or unused request has its
// result registered at the accept edge. New requests are taken only while idle.
//
// Reset: the block clears all NUM_ENTRIES entries of the store, one entry a cycle,
// holding in_tready low; configuration writes are taken during this pass.
// Stall: the result register holds until out_tready; a new request is taken in
// the same cycle the pending result leaves, and not while it is blocked.
module palette_table_masked_write #(
  parameter int unsigned NUM_ENTRIES = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // opcode[1:0], index[9:2], red[17:10], green[25:18], blue[33:26], zero pad
  input  logic [pmw_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // ok[0], red_out[8:1], green_out[16:9], blue_out[24:17], zero pad
  output logic [pmw_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pmw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pmw_pkg::*;

  pmw_cmd_t         cmd;
  pmw_sts_t         sts;
  logic [OPC_W-1:0] in_opcode;
  logic [IDX_W-1:0] in_index;
  logic [CH_W-1:0]  in_red, in_green, in_blue;
  logic             res_ok;
  logic [CH_W-1:0]  res_red, res_green, res_blue;

  assign in_opcode = in_tdata[1:0];
  assign in_index  = in_tdata[9:2];
  assign in_red    = in_tdata[17:10];
  assign in_green  = in_tdata[25:18];
  assign in_blue   = in_tdata[33:26];

  assign cfg_ready = 1'b1;

  pmw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_opcode  (in_opcode),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pmw_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_index  (in_index),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .cmd       (cmd),
    .sts       (sts),
    .out_ok    (res_ok),
    .out_red   (res_red),
    .out_green (res_green),
    .out_blue  (res_blue)
  );

  assign out_tdata = {7'd0, res_blue, res_green, res_red, res_ok};

endmodule
